>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the framebuffer blitter rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> rtl/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// shared types and constants of the page framebuffer blitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfb_pkg;

    localparam int BYTE_W     = 8;
    localparam int PG_W       = 5;  // page arithmetic, holds one past the last page
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_RIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_TOP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_PAGES = 2'd3;

    localparam logic [7:0] WIN_LEFT_RST  = 8'd0;
    localparam logic [7:0] WIN_RIGHT_RST = 8'd128;
    localparam logic [2:0] WIN_TOP_RST   = 3'd0;
    localparam logic [3:0] WIN_PAGES_RST = 4'd8;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_PLOT  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic accept;    // latch the input item
        logic clear;     // write one zero entry of the clearing pass
        logic beg1;      // begin item, first step
        logic beg2;      // begin item, second step
        logic plan;      // work out the write plan of the latched item
        logic rd0;       // read first framebuffer byte
        logic wr0;       // write first byte, read second
        logic wr1;       // write second byte
        logic out_load;  // load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        t_cmd item_cmd;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/page_framebuffer_blitter.sv
// ----------------------------------------------------------------------------
// page_framebuffer_blitter
// page-organized monochrome framebuffer with a clipped bitmap blitter
// ----------------------------------------------------------------------------
// After reset the block zeroes the framebuffer one byte a cycle, every memory
// entry of 2**(max(1, clog2(FB_PAGES)) + clog2(FB_WIDTH)) (1024 at
// the defaults); it takes no item until then, while window register writes are
// taken at once. Items are handled one at a time through a framebuffer memory
// with one write and one read port: a begin item runs its begin steps, a bitmap
// byte or a point runs plan, read, write first page and read second, and write
// second page, and a read runs plan and read, then waits until the output
// register is free to load its result.
`timescale 1ns / 1ps
`default_nettype none

module page_framebuffer_blitter import pfb_pkg::*; #(
    parameter int FB_WIDTH = 128,
    parameter int FB_PAGES = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_cmd,
    input  wire logic signed [8:0]     i_pos_x,
    input  wire logic signed [8:0]     i_pos_y,
    input  wire logic [7:0]            i_blit_width,
    input  wire logic [7:0]            i_blit_height,
    input  wire logic                  i_draw_mode,
    input  wire logic [7:0]            i_pixel_byte,
    input  wire logic [2:0]            i_read_page,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [7:0]                 o_read_byte
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    pfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_dp_cmd   (dp_cmd)
    );

    pfb_datapath #(
        .FB_WIDTH (FB_WIDTH),
        .FB_PAGES (FB_PAGES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (i_cmd),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_blit_width  (i_blit_width),
        .i_blit_height (i_blit_height),
        .i_draw_mode   (i_draw_mode),
        .i_pixel_byte  (i_pixel_byte),
        .i_read_page   (i_read_page),
        .i_dp_cmd      (dp_cmd),
        .o_status      (dp_status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_byte   (o_read_byte)
    );

endmodule

`default_nettype wire

>>> rtl/pfb_ctrl.sv
// ----------------------------------------------------------------------------
// pfb_ctrl
// sequencer: clearing pass, item dispatch and read-modify-write steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pfb_ctrl import pfb_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_cmd,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_dp_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BEG1,
        S_BEG2,
        S_PLAN,
        S_RD0,
        S_WR0,
        S_WR1,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_dp_cmd   = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_dp_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_dp_cmd.accept = 1'b1;
                    n_state = (t_cmd'(i_cmd) == CMD_BEGIN) ? S_BEG1 : S_PLAN;
                end
            end
            S_BEG1: begin
                o_dp_cmd.beg1 = 1'b1;
                n_state = S_BEG2;
            end
            S_BEG2: begin
                o_dp_cmd.beg2 = 1'b1;
                n_state = S_IDLE;
            end
            S_PLAN: begin
                o_dp_cmd.plan = 1'b1;
                n_state = S_RD0;
            end
            S_RD0: begin
                o_dp_cmd.rd0 = 1'b1;
                n_state = (i_status.item_cmd == CMD_READ) ? S_OUT : S_WR0;
            end
            S_WR0: begin
                o_dp_cmd.wr0 = 1'b1;
                n_state = S_WR1;
            end
            S_WR1: begin
                o_dp_cmd.wr1 = 1'b1;
                n_state = S_IDLE;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_dp_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, o_dp_cmd.accept, r_state != S_IDLE)

endmodule

`default_nettype wire

>>> rtl/pfb_datapath.sv
// ----------------------------------------------------------------------------
// pfb_datapath
// window registers, blit state, write planning and the framebuffer memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pfb_datapath import pfb_pkg::*; #(
    parameter int FB_WIDTH = 128,
    parameter int FB_PAGES = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [1:0]            i_cmd,
    input  wire logic signed [8:0]     i_pos_x,
    input  wire logic signed [8:0]     i_pos_y,
    input  wire logic [7:0]            i_blit_width,
    input  wire logic [7:0]            i_blit_height,
    input  wire logic                  i_draw_mode,
    input  wire logic [7:0]            i_pixel_byte,
    input  wire logic [2:0]            i_read_page,
    input  wire t_dp_cmd               i_dp_cmd,
    output t_dp_status                 o_status,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [BYTE_W-1:0]          o_read_byte
);

    localparam int CW    = $clog2(FB_WIDTH);
    localparam int PW    = (FB_PAGES > 1) ? $clog2(FB_PAGES) : 1;
    localparam int AW    = PW + CW;
    localparam int DEPTH = 1 << AW;

    localparam logic [PG_W-1:0]   NPAGES  = PG_W'(FB_PAGES);
    localparam logic signed [9:0] COL_LIM = 10'(FB_WIDTH);
    localparam logic [8:0]        X_LIM   = 9'(FB_WIDTH);
    localparam logic [8:0]        Y_LIM   = 9'(FB_PAGES * 8);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_STRADDLE,
        PH_ROWS
    } t_phase;

    // window registers
    logic [7:0] r_win_left;
    logic [7:0] r_win_right;
    logic [2:0] r_win_top;
    logic [3:0] r_win_pages;

    // latched item
    t_cmd              r_cmd;
    logic signed [8:0] r_x;
    logic signed [8:0] r_y;
    logic [7:0]        r_w;
    logic [7:0]        r_h;
    logic              r_mode;
    logic [7:0]        r_byte;
    logic [2:0]        r_rp;

    // blit state
    t_phase            r_phase,     n_phase;
    logic signed [8:0] r_origin,    n_origin;
    logic signed [8:0] r_row_y,     n_row_y;
    logic [7:0]        r_cols,      n_cols;
    logic [7:0]        r_cursor,    n_cursor;
    logic signed [8:0] r_rows_left, n_rows_left;
    logic [13:0]       r_skip,      n_skip;
    logic              r_set,       n_set;
    logic [5:0]        r_n;

    // write plan
    logic [PG_W-1:0]   r_pg0,    n_pg0;
    logic [PG_W-1:0]   r_pg1,    n_pg1;
    logic [CW-1:0]     r_col,    n_col;
    logic [7:0]        r_bits0,  n_bits0;
    logic [7:0]        r_bits1,  n_bits1;
    logic              r_en0,    n_en0;
    logic              r_en1,    n_en1;
    logic              r_op_set, n_op_set;

    // memory and result
    logic [7:0]        r_mem [0:DEPTH-1];
    logic [7:0]        r_rdata;
    logic [AW-1:0]     r_clr_addr;
    logic              r_out_valid;
    logic [7:0]        r_read_byte;

    // window geometry
    logic [PG_W-1:0]   top_ext;
    logic [PG_W-1:0]   rem_pages;
    logic [PG_W-1:0]   pg_cnt;
    logic [PG_W-1:0]   end_page;
    logic [5:0]        t_row;

    // begin arithmetic
    logic signed [9:0] beg_d;
    logic [8:0]        n8;
    logic signed [9:0] h_adj;
    logic signed [9:0] y_adj;

    // byte arithmetic
    logic signed [9:0] col;
    logic              col_ok;
    logic signed [9:0] diff;
    logic [3:0]        k_str;
    logic [2:0]        k3;
    logic [PG_W-1:0]   row_page;
    logic [PG_W-1:0]   row_page1;
    logic [7:0]        bits_str;
    logic [7:0]        bits_lo;
    logic [7:0]        bits_hi;
    logic [8:0]        cur_inc;
    logic              row_done;
    logic signed [8:0] new_row;
    logic signed [8:0] new_rows_left;
    logic              rows_end;
    logic              plot_ok;
    logic              read_ok;

    // memory port
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [AW-1:0]     addr0;
    logic [AW-1:0]     addr1;

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left  <= WIN_LEFT_RST;
            r_win_right <= WIN_RIGHT_RST;
            r_win_top   <= WIN_TOP_RST;
            r_win_pages <= WIN_PAGES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIN_LEFT:  r_win_left  <= i_cfg_data;
                CFG_WIN_RIGHT: r_win_right <= i_cfg_data;
                CFG_WIN_TOP:   r_win_top   <= i_cfg_data[2:0];
                CFG_WIN_PAGES: r_win_pages <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // item latch
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.accept) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_w    <= i_blit_width;
            r_h    <= i_blit_height;
            r_mode <= i_draw_mode;
            r_byte <= i_pixel_byte;
            r_rp   <= i_read_page;
        end
    end

    // ------------------------------------------------------------------------
    // window geometry
    // ------------------------------------------------------------------------
    always_comb begin
        top_ext   = PG_W'(r_win_top);
        rem_pages = (NPAGES > top_ext) ? (NPAGES - top_ext) : '0;
        pg_cnt    = (PG_W'(r_win_pages) > rem_pages) ? rem_pages : PG_W'(r_win_pages);
        end_page  = top_ext + pg_cnt;
        t_row     = {r_win_top, 3'b000};
    end

    // ------------------------------------------------------------------------
    // begin arithmetic
    // ------------------------------------------------------------------------
    assign beg_d = $signed({4'b0000, t_row}) - $signed({r_y[8], r_y});

    // whole rows above the window top are counted off
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.beg1) begin
            r_n <= (beg_d > 10'sd8) ? beg_d[8:3] : 6'd0;
        end
    end

    assign n8    = {r_n, 3'b000};
    assign h_adj = $signed({2'b00, r_h}) - $signed({1'b0, n8});
    assign y_adj = $signed({r_y[8], r_y}) + $signed({1'b0, n8});

    // ------------------------------------------------------------------------
    // byte arithmetic
    // ------------------------------------------------------------------------
    assign col    = $signed({r_origin[8], r_origin}) + $signed({2'b00, r_cursor});
    assign col_ok = (col >= $signed({2'b00, r_win_left}))
                 && (col < $signed({2'b00, r_win_right}))
                 && (col < COL_LIM);
    assign diff   = $signed({4'b0000, t_row}) - $signed({r_row_y[8], r_row_y});

    always_comb begin
        if (diff < 10'sd0) begin
            k_str = 4'd0;
        end else if (diff > 10'sd8) begin
            k_str = 4'd8;
        end else begin
            k_str = diff[3:0];
        end
    end

    assign k3            = r_row_y[2:0];
    assign row_page      = PG_W'(r_row_y[7:3]);
    assign row_page1     = row_page + 1'b1;
    assign bits_str      = r_byte >> k_str;
    assign bits_lo       = r_byte << k3;
    assign bits_hi       = r_byte >> (4'd8 - {1'b0, k3});
    assign cur_inc       = {1'b0, r_cursor} + 9'd1;
    assign row_done      = cur_inc >= {1'b0, r_cols};
    assign new_row       = r_row_y + 9'sd8;
    assign new_rows_left = r_rows_left - 9'sd8;
    assign rows_end      = (new_rows_left < 9'sd1) || (PG_W'(new_row[7:3]) >= end_page);

    assign plot_ok = !r_x[8] && ({1'b0, r_x[7:0]} < X_LIM)
                  && !r_y[8] && ({1'b0, r_y[7:0]} < Y_LIM);
    assign read_ok = !r_x[8] && ({1'b0, r_x[7:0]} < X_LIM) && (PG_W'(r_rp) < NPAGES);

    // ------------------------------------------------------------------------
    // blit state and write plan
    // ------------------------------------------------------------------------
    always_comb begin
        n_phase     = r_phase;
        n_origin    = r_origin;
        n_row_y     = r_row_y;
        n_cols      = r_cols;
        n_cursor    = r_cursor;
        n_rows_left = r_rows_left;
        n_skip      = r_skip;
        n_set       = r_set;
        n_pg0       = r_pg0;
        n_pg1       = r_pg1;
        n_col       = r_col;
        n_bits0     = r_bits0;
        n_bits1     = r_bits1;
        n_en0       = r_en0;
        n_en1       = r_en1;
        n_op_set    = r_op_set;
        if (i_dp_cmd.beg2) begin
            n_origin    = r_x;
            n_cols      = r_w;
            n_set       = r_mode;
            n_cursor    = '0;
            n_skip      = 14'(r_n) * 14'(r_w);
            n_row_y     = y_adj[8:0];
            n_rows_left = h_adj[8:0];
            if ((r_w == 8'd0) || (r_h == 8'd0) || (h_adj < 10'sd1)) begin
                n_phase = PH_IDLE;
            end else if (y_adj < $signed({4'b0000, t_row})) begin
                n_phase = PH_STRADDLE;
            end else if (PG_W'(y_adj[7:3]) >= end_page) begin
                n_phase = PH_IDLE;
            end else begin
                n_phase = PH_ROWS;
            end
        end else if (i_dp_cmd.plan) begin
            n_en0 = 1'b0;
            n_en1 = 1'b0;
            case (r_cmd)
                CMD_BYTE: begin
                    if (r_phase != PH_IDLE) begin
                        if (r_skip != '0) begin
                            n_skip = r_skip - 1'b1;
                        end else begin
                            n_col    = col[CW-1:0];
                            n_op_set = r_set;
                            if (r_phase == PH_STRADDLE) begin
                                // row straddles the top: shift down into the top page
                                n_pg0   = top_ext;
                                n_bits0 = bits_str;
                                n_en0   = col_ok && (top_ext < NPAGES);
                            end else begin
                                n_pg0   = row_page;
                                n_pg1   = row_page1;
                                n_bits0 = bits_lo;
                                n_bits1 = bits_hi;
                                n_en0   = col_ok && (row_page < NPAGES);
                                n_en1   = col_ok && (k3 != 3'd0) && (row_page1 < end_page)
                                       && (row_page1 < NPAGES);
                            end
                            if (row_done) begin
                                n_cursor    = '0;
                                n_row_y     = new_row;
                                n_rows_left = new_rows_left;
                                n_phase     = rows_end ? PH_IDLE : PH_ROWS;
                            end else begin
                                n_cursor = cur_inc[7:0];
                            end
                        end
                    end
                end
                CMD_PLOT: begin
                    n_pg0    = PG_W'(r_y[7:3]);
                    n_col    = r_x[CW-1:0];
                    n_bits0  = 8'd1 << r_y[2:0];
                    n_en0    = plot_ok;
                    n_op_set = r_mode;
                end
                CMD_READ: begin
                    n_pg0 = PG_W'(r_rp);
                    n_col = r_x[CW-1:0];
                    n_en0 = read_ok;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_en0   <= 1'b0;
            r_en1   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_en0   <= n_en0;
            r_en1   <= n_en1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_origin    <= n_origin;
        r_row_y     <= n_row_y;
        r_cols      <= n_cols;
        r_cursor    <= n_cursor;
        r_rows_left <= n_rows_left;
        r_skip      <= n_skip;
        r_set       <= n_set;
        r_pg0       <= n_pg0;
        r_pg1       <= n_pg1;
        r_col       <= n_col;
        r_bits0     <= n_bits0;
        r_bits1     <= n_bits1;
        r_op_set    <= n_op_set;
    end

    // ------------------------------------------------------------------------
    // framebuffer memory
    // ------------------------------------------------------------------------
    assign addr0 = {r_pg0[PW-1:0], r_col};
    assign addr1 = {r_pg1[PW-1:0], r_col};

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = addr0;
        if (i_dp_cmd.clear) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
        end else if (i_dp_cmd.rd0) begin
            mem_re = 1'b1;
        end else if (i_dp_cmd.wr0) begin
            mem_we    = r_en0;
            mem_wdata = r_op_set ? (r_rdata | r_bits0) : (r_rdata & ~r_bits0);
            mem_re    = 1'b1;
            mem_raddr = addr1;
        end else if (i_dp_cmd.wr1) begin
            mem_we    = r_en1;
            mem_waddr = addr1;
            mem_wdata = r_op_set ? (r_rdata | r_bits1) : (r_rdata & ~r_bits1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_dp_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.out_load) begin
            r_read_byte <= r_en0 ? r_rdata : 8'd0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_byte         = r_read_byte;
    assign o_status.clear_last = &r_clr_addr;
    assign o_status.item_cmd   = r_cmd;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    `ASSERT_IMPLY(a_rows_in_range, i_clk, i_rst_n, r_phase == PH_ROWS, !r_row_y[8] && (r_rows_left > 9'sd0))
    `ASSERT_IMPLY(a_spill_next_page, i_clk, i_rst_n, r_en1, r_pg1 == (r_pg0 + 1'b1))
    `ASSERT_IMPLY(a_out_from_load, i_clk, i_rst_n, $rose(r_out_valid), $past(i_dp_cmd.out_load))

endmodule

`default_nettype wire

>>> dv/tb_page_framebuffer_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_framebuffer_blitter
// self-checking bench: drives blits, points and reads through the handshake,
// keeps a shadow framebuffer and compares every returned read byte in order
// ----------------------------------------------------------------------------

module tb_page_framebuffer_blitter;
    import pfb_pkg::*;

    localparam int FB_W         = 128;
    localparam int FB_PG        = 8;
    localparam int IDLE_LIMIT   = 20000;
    localparam int PHASE_ITEMS  = 250;
    localparam int NUM_PHASES   = 8;
    localparam int SETTLE       = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        t_cmd              cmd;
        logic signed [8:0] pos_x;
        logic signed [8:0] pos_y;
        logic [7:0]        blit_width;
        logic [7:0]        blit_height;
        logic              draw_mode;
        logic [7:0]        pixel_byte;
        logic [2:0]        read_page;
    } fb_item_t;

    typedef enum {BLIT_OFF, BLIT_STRADDLE, BLIT_ROWS} blit_state_e;

    // shadow framebuffer and blit state, plus the queue of read bytes due
    class page_fb_tracker;
        logic [7:0]  fb_mem [FB_PG*FB_W];
        int          left_col, right_col, top_page, page_count;
        int          org_x, row_y, rows_left, col_idx, col_count, skip_left;
        blit_state_e state;
        bit          set_mode;
        logic [7:0]  read_bytes_due [$];
        int          fails;

        function new();
            foreach (fb_mem[i]) fb_mem[i] = 8'h00;
            left_col   = int'(WIN_LEFT_RST);
            right_col  = int'(WIN_RIGHT_RST);
            top_page   = int'(WIN_TOP_RST);
            page_count = int'(WIN_PAGES_RST);
            org_x      = 0;
            row_y      = 0;
            rows_left  = 0;
            col_idx    = 0;
            col_count  = 0;
            skip_left  = 0;
            state      = BLIT_OFF;
            set_mode   = 1'b0;
            fails      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WIN_LEFT:  left_col = int'(data);
                CFG_WIN_RIGHT: right_col = int'(data);
                CFG_WIN_TOP:   top_page = int'(data[2:0]);
                CFG_WIN_PAGES: page_count = int'(data[3:0]);
                default: ;
            endcase
        endfunction

        // one past the last window page
        function int window_end();
            int rem, p;
            rem = (FB_PG > top_page) ? FB_PG - top_page : 0;
            p = (page_count > rem) ? rem : page_count;
            return top_page + p;
        endfunction

        function void merge(int page, int col, logic [7:0] bits);
            int idx;
            if (page < 0 || page >= FB_PG) return;
            if (col < left_col || col >= right_col || col >= FB_W) return;
            idx = page * FB_W + col;
            if (set_mode) fb_mem[idx] = fb_mem[idx] | bits;
            else fb_mem[idx] = fb_mem[idx] & ~bits;
        endfunction

        function void next_row_state();
            if (rows_left < 1 || (row_y >>> 3) >= window_end()) state = BLIT_OFF;
            else state = BLIT_ROWS;
        endfunction

        function void open_blit(fb_item_t it);
            int t, y, h, n;
            t = top_page * 8;
            y = int'(it.pos_y);
            h = int'(it.blit_height);
            state = BLIT_OFF;
            skip_left = 0;
            col_idx = 0;
            org_x = int'(it.pos_x);
            col_count = int'(it.blit_width);
            set_mode = it.draw_mode;
            if (col_count == 0 || h < 1) return;
            // rows wholly above the window top are counted off
            if (y < t - 8) begin
                n = (t - y) / 8;
                h = h - n * 8;
                if (h < 1) return;
                skip_left = n * col_count;
                y = y + n * 8;
            end
            row_y = y;
            rows_left = h;
            if (y < t) state = BLIT_STRADDLE;
            else next_row_state();
        endfunction

        function void blit_byte(logic [7:0] b);
            int col, k, page;
            logic [7:0] lo, hi;
            if (state == BLIT_OFF) return;
            if (skip_left > 0) begin
                skip_left--;
                return;
            end
            col = org_x + col_idx;
            if (state == BLIT_STRADDLE) begin
                k = top_page * 8 - row_y;
                if (k < 0) k = 0;
                if (k > 8) k = 8;
                lo = b >> k;
                merge(top_page, col, lo);
            end else begin
                k = row_y & 7;
                page = row_y >>> 3;
                lo = b << k;
                hi = b >> (8 - k);
                merge(page, col, lo);
                if (k != 0 && page + 1 < window_end()) merge(page + 1, col, hi);
            end
            col_idx++;
            if (col_idx >= col_count) begin
                col_idx = 0;
                row_y = row_y + 8;
                rows_left = rows_left - 8;
                next_row_state();
            end
        endfunction

        function void plot_point(fb_item_t it);
            int x, y, idx;
            logic [7:0] bitmask;
            x = int'(it.pos_x);
            y = int'(it.pos_y);
            if (x < 0 || x >= FB_W || y < 0 || y >= FB_PG * 8) return;
            idx = (y >>> 3) * FB_W + x;
            bitmask = 8'h01 << (y & 7);
            if (it.draw_mode) fb_mem[idx] = fb_mem[idx] | bitmask;
            else fb_mem[idx] = fb_mem[idx] & ~bitmask;
        endfunction

        function void draw_item(fb_item_t it);
            int x;
            x = int'(it.pos_x);
            case (it.cmd)
                CMD_BEGIN: open_blit(it);
                CMD_BYTE:  blit_byte(it.pixel_byte);
                CMD_PLOT:  plot_point(it);
                CMD_READ: begin
                    if (x >= 0 && x < FB_W && int'(it.read_page) < FB_PG)
                        read_bytes_due.push_back(fb_mem[int'(it.read_page) * FB_W + x]);
                    else
                        read_bytes_due.push_back(8'h00);
                end
                default: ;
            endcase
        endfunction

        function void note_fail(string msg);
            if (fails < 10) $display("%s", msg);
            fails++;
        endfunction

        function void compare_read_byte(logic [7:0] got);
            logic [7:0] want;
            if (read_bytes_due.size() == 0) begin
                note_fail($sformatf("read_byte %02h with no read pending", got));
                return;
            end
            want = read_bytes_due.pop_front();
            if (got !== want)
                note_fail($sformatf("read_byte expected %02h got %02h", want, got));
        endfunction

        function int pending();
            return read_bytes_due.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = CFG_WIN_LEFT;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [1:0]              i_cmd = CMD_BEGIN;
    logic signed [8:0]       i_pos_x = '0;
    logic signed [8:0]       i_pos_y = '0;
    logic [7:0]              i_blit_width = '0;
    logic [7:0]              i_blit_height = '0;
    logic                    i_draw_mode = 1'b0;
    logic [7:0]              i_pixel_byte = '0;
    logic [2:0]              i_read_page = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [7:0]              o_read_byte;

    page_fb_tracker fb_track;
    int send_idle_pct = 21;
    int recv_idle_pct = 50;
    int hold_request = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int items_sent = 0;
    int win_top_now = 0;

    page_framebuffer_blitter #(
        .FB_WIDTH (FB_W),
        .FB_PAGES (FB_PG)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_blit_width  (i_blit_width),
        .i_blit_height (i_blit_height),
        .i_draw_mode   (i_draw_mode),
        .i_pixel_byte  (i_pixel_byte),
        .i_read_page   (i_read_page),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_byte   (o_read_byte)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_out_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) fb_track.compare_read_byte(o_read_byte);
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic fb_item_t noise_item();
        fb_item_t it;
        it.cmd         = t_cmd'(2'($urandom_range(3)));
        it.pos_x       = 9'($urandom);
        it.pos_y       = 9'($urandom);
        it.blit_width  = 8'($urandom);
        it.blit_height = 8'($urandom);
        it.draw_mode   = 1'($urandom);
        it.pixel_byte  = 8'($urandom);
        it.read_page   = 3'($urandom);
        return it;
    endfunction

    function automatic fb_item_t mk_item(t_cmd c, int x, int y, int w, int h, bit m,
                                         int pix, int pg);
        fb_item_t it;
        it.cmd         = c;
        it.pos_x       = 9'(x);
        it.pos_y       = 9'(y);
        it.blit_width  = 8'(w);
        it.blit_height = 8'(h);
        it.draw_mode   = m;
        it.pixel_byte  = 8'(pix);
        it.read_page   = 3'(pg);
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input fb_item_t it);
        int gap;
        gap = 0;
        if (int'($urandom_range(99)) < send_idle_pct) gap = $urandom_range(1, 4);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= it.cmd;
        i_pos_x       <= it.pos_x;
        i_pos_y       <= it.pos_y;
        i_blit_width  <= it.blit_width;
        i_blit_height <= it.blit_height;
        i_draw_mode   <= it.draw_mode;
        i_pixel_byte  <= it.pixel_byte;
        i_read_page   <= it.read_page;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        fb_track.draw_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_read(input int x, input int pg);
        fb_item_t it;
        it = noise_item();
        it.cmd = CMD_READ;
        it.pos_x = 9'(x);
        it.read_page = 3'(pg);
        send_item(it);
    endtask

    function automatic int pick_col();
        if ($urandom_range(9) == 0) return int'($urandom_range(511)) - 256;
        return int'($urandom_range(FB_W - 1));
    endfunction

    // a read or a point, mostly inside the store
    task automatic send_side_item();
        fb_item_t it;
        it = noise_item();
        if ($urandom_range(1) == 0) begin
            send_read(pick_col(), $urandom_range(7));
        end else begin
            it.cmd = CMD_PLOT;
            it.pos_x = 9'(pick_col());
            if ($urandom_range(9) != 0) it.pos_y = 9'($urandom_range(FB_PG * 8 - 1));
            send_item(it);
        end
    endtask

    task automatic run_blit();
        fb_item_t it;
        int w, h, nbytes, x0;
        it = noise_item();
        it.cmd = CMD_BEGIN;
        if ($urandom_range(9) == 0) x0 = int'($urandom_range(511)) - 256;
        else x0 = int'($urandom_range(160)) - 20;
        it.pos_x = 9'(x0);
        if ($urandom_range(9) != 0) it.pos_y = 9'(int'($urandom_range(100)) - 30);
        case ($urandom_range(19))
            0:       w = 0;
            1, 2:    w = $urandom_range(255);
            default: w = $urandom_range(1, 12);
        endcase
        case ($urandom_range(19))
            0:       h = 0;
            1, 2:    h = $urandom_range(255);
            default: h = $urandom_range(1, 24);
        endcase
        it.blit_width = 8'(w);
        it.blit_height = 8'(h);
        send_item(it);
        nbytes = w * ((h + 7) / 8);
        if (nbytes > 48) nbytes = 48;
        // now and then a short or overlong byte stream
        if ($urandom_range(7) == 0) nbytes = $urandom_range(nbytes + 4);
        repeat (nbytes) begin
            if ($urandom_range(4) == 0) send_side_item();
            it = noise_item();
            it.cmd = CMD_BYTE;
            send_item(it);
        end
        repeat (3) send_read(x0 + int'($urandom_range(13)) - 1, $urandom_range(7));
    endtask

    // no transfer in flight: all reads back and the last item worked off
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (fb_track.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 8'(value);
        fb_track.write_reg(idx, 8'(value));
        @(negedge i_clk);
    endtask

    task automatic write_window(input int l, input int r, input int t, input int p);
        cfg_write(CFG_WIN_LEFT, l);
        cfg_write(CFG_WIN_RIGHT, r);
        cfg_write(CFG_WIN_TOP, t);
        cfg_write(CFG_WIN_PAGES, p);
        i_cfg_we <= 1'b0;
        win_top_now = t;
    endtask

    initial begin
        fb_item_t it;
        int ph, target, l;
        fb_track = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_window(0, 128, 0, 8);

        // directed: field extremes, stray bytes, empty blits, abandoned blit
        send_item(mk_item(CMD_READ, -256, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(CMD_READ, 255, 0, 255, 255, 1, 255, 7));
        send_item(mk_item(CMD_PLOT, 0, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_PLOT, 127, 63, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_PLOT, -1, 5, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_PLOT, 128, 0, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_PLOT, 5, 64, 0, 0, 1, 0, 0));
        send_item(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(CMD_READ, 127, 0, 0, 0, 0, 0, 7));
        send_item(mk_item(CMD_PLOT, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(CMD_BEGIN, 0, 0, 0, 8, 1, 0, 0));
        send_item(mk_item(CMD_BEGIN, 0, 0, 4, 0, 1, 0, 0));
        send_item(mk_item(CMD_BYTE, 0, 0, 0, 0, 0, 255, 0));
        send_item(mk_item(CMD_BEGIN, -1, -3, 2, 9, 1, 0, 0));
        send_item(mk_item(CMD_BYTE, 0, 0, 0, 0, 0, 255, 0));
        send_item(mk_item(CMD_BYTE, 0, 0, 0, 0, 0, 129, 0));
        send_item(mk_item(CMD_BYTE, 0, 0, 0, 0, 0, 255, 0));
        send_item(mk_item(CMD_BYTE, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(CMD_BYTE, 0, 0, 0, 0, 0, 85, 0));
        send_item(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(CMD_BEGIN, 126, 60, 3, 255, 0, 0, 0));
        send_item(mk_item(CMD_BYTE, 0, 0, 0, 0, 0, 255, 0));
        send_item(mk_item(CMD_BEGIN, 10, -256, 255, 255, 1, 0, 0));
        send_item(mk_item(CMD_BYTE, 0, 0, 0, 0, 0, 255, 0));
        send_item(mk_item(CMD_READ, 126, 0, 0, 0, 0, 0, 7));

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = (ph < 3) ? 21 : (ph < 6) ? 50 : 0;
            recv_idle_pct = (ph < 3) ? 50 : (ph < 6) ? 21 : 0;
            wait_quiet();
            case (ph)
                0: write_window(0, 128, 0, 8);
                1: write_window(128, 0, 7, 8);
                2: write_window(5, 120, 3, 2);
                3: write_window(0, 128, 7, 1);
                4: write_window(0, 128, 2, 0);
                default: begin
                    l = $urandom_range(128);
                    if ($urandom_range(3) == 0)
                        write_window(l, $urandom_range(128), $urandom_range(7),
                                     $urandom_range(8));
                    else
                        write_window(l, $urandom_range(l, 128), $urandom_range(7),
                                     $urandom_range(8));
                end
            endcase
            // the blit left open by the previous phase goes on under the new window
            repeat (4) begin
                it = noise_item();
                it.cmd = CMD_BYTE;
                send_item(it);
            end
            if (ph == 6) begin
                @(posedge i_clk);
                hold_request = HOLD_CYCLES;
                @(negedge i_clk);
                repeat (24) send_read(pick_col(), $urandom_range(7));
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(5) == 0) begin
                    repeat (6) send_item(noise_item());
                end else begin
                    run_blit();
                end
            end
            // open a blit that straddles the window top and leave it open
            send_item(mk_item(CMD_BEGIN, $urandom_range(120), win_top_now * 8 -
                              int'($urandom_range(1, 7)), 3, 20, 1'($urandom), 0, 0));
            repeat (2) begin
                it = noise_item();
                it.cmd = CMD_BYTE;
                send_item(it);
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fb_track.fails == 0 && fb_track.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/pfb_pkg.sv
rtl/pfb_ctrl.sv
rtl/pfb_datapath.sv
rtl/page_framebuffer_blitter.sv
dv/tb_page_framebuffer_blitter.sv
